>>> hdl/fdsg_pkg.sv
// ----------------------------------------------------------------------------
// Filled disc span generator package
// Shared widths, defaults, state codes and the structs passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsg_pkg;

	localparam int DEF_SCREEN_WIDTH  = 256;
	localparam int DEF_SCREEN_HEIGHT = 256;
	localparam int DEF_MAX_RADIUS    = 31;

	localparam int CX_W     = 10;
	localparam int CY_W     = 10;
	localparam int RAD_W    = 5;
	localparam int COL_W    = 8;
	localparam int STRIDE_W = 11;
	localparam int ROW_W    = 8;
	localparam int START_W  = 8;
	localparam int LEN_W    = 9;
	localparam int ADDR_W   = 18;

	localparam int DY_W  = RAD_W + 1;   // signed row offset -31..31
	localparam int REM_W = 10;          // r^2 - dy^2, up to 961
	localparam int SQ_W  = 11;          // (dx+1)^2, up to 1024

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 56;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd256;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ADJ   = 4'b0010,
		ST_ROW   = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	typedef struct packed {
		logic             settled;
		logic [RAD_W-1:0] dx_next;
		logic [SQ_W-1:0]  sq_next;
	} hw_step_t;

	typedef struct packed {
		logic               visible;
		logic [ROW_W-1:0]   row;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [ADDR_W-1:0]  address;
	} span_t;

endpackage

`default_nettype wire

>>> hdl/fdsg_hw_unit.sv
// ----------------------------------------------------------------------------
// Half width step unit
// One compare-and-step of the half width: grow or shrink dx by one, or settle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsg_hw_unit (
	input  logic [fdsg_pkg::RAD_W-1:0] dx,
	input  logic [fdsg_pkg::SQ_W-1:0]  sq,      // (dx+1)^2
	input  logic [fdsg_pkg::REM_W-1:0] rem,     // r^2 - dy^2
	input  logic [fdsg_pkg::RAD_W-1:0] radius,
	output fdsg_pkg::hw_step_t         step
);

	logic [fdsg_pkg::SQ_W-1:0] odd;     // 2*dx + 1
	logic [fdsg_pkg::SQ_W-1:0] sq_dn;   // dx^2
	logic [fdsg_pkg::SQ_W-1:0] rem_x;
	logic                      inc;
	logic                      dec;

	assign odd   = {{(fdsg_pkg::SQ_W-fdsg_pkg::RAD_W-1){1'b0}}, dx, 1'b1};
	assign sq_dn = sq - odd;
	assign rem_x = {{(fdsg_pkg::SQ_W-fdsg_pkg::REM_W){1'b0}}, rem};

	// at most one of these holds: sq <= rem implies dx^2 <= rem
	assign inc = (dx < radius) && (sq <= rem_x);
	assign dec = (dx != '0) && (sq_dn > rem_x);

	always_comb begin
		step.settled = !inc && !dec;
		step.dx_next = dx;
		step.sq_next = sq;
		if (inc) begin
			step.dx_next = dx + 1'b1;
			step.sq_next = sq + odd + 11'd2;
		end else if (dec) begin
			step.dx_next = dx - 1'b1;
			step.sq_next = sq_dn;
		end
	end

endmodule

`default_nettype wire

>>> hdl/fdsg_span_unit.sv
// ----------------------------------------------------------------------------
// Span clip and address unit
// Clip one row's span to the screen and form its framebuffer address.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsg_span_unit #(
	parameter int SCREEN_WIDTH  = fdsg_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fdsg_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic signed [fdsg_pkg::CX_W-1:0]  cx,
	input  logic signed [fdsg_pkg::CY_W-1:0]  cy,
	input  logic signed [fdsg_pkg::DY_W-1:0]  dy,
	input  logic        [fdsg_pkg::RAD_W-1:0] dx,
	input  logic        [fdsg_pkg::STRIDE_W-1:0] stride,
	output fdsg_pkg::span_t                   span
);

	localparam logic signed [10:0] SW_L = 11'(SCREEN_WIDTH);
	localparam logic signed [10:0] SH_L = 11'(SCREEN_HEIGHT);

	logic signed [10:0] y;
	logic signed [10:0] x0;
	logic signed [10:0] x1;
	logic signed [10:0] x0c;
	logic signed [10:0] x1c;
	logic signed [10:0] len;
	logic        [18:0] prod;

	assign y  = {cy[9], cy} + {{5{dy[5]}}, dy};
	assign x0 = {cx[9], cx} - $signed({6'b0, dx});
	assign x1 = {cx[9], cx} + $signed({6'b0, dx}) + 11'sd1;

	assign x0c = (x0 < 11'sd0) ? 11'sd0 : x0;
	assign x1c = (x1 > SW_L) ? SW_L : x1;
	assign len = x1c - x0c;

	assign prod = 19'(y[7:0]) * 19'(stride);

	always_comb begin
		span.visible = (y >= 11'sd0) && (y < SH_L) && (x0c < x1c);
		span.row     = y[7:0];
		span.start   = x0c[7:0];
		span.length  = len[8:0];
		span.address = prod[17:0] + 18'(x0c[7:0]);
	end

endmodule

`default_nettype wire

>>> hdl/filled_disc_span_generator_top.sv
// ----------------------------------------------------------------------------
// Filled disc span generator
// Turns one disc command into clipped horizontal fill spans, one per visible row.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one disc command per item. The block takes a command only
//   when idle; s_tready stays low while a disc is being walked.
//   m_* delivers one span per visible row, top row first; m_tlast marks the
//   final span of the disc. A disc that is fully off screen yields no item.
//   cfg_* writes line_stride; it is always ready and must be written only
//   while the block is idle.
// Timing:
//   One shared compare-and-step unit moves the half width by one pixel per
//   cycle. Each of the 2r+1 rows takes a settle step in ST_ADJ and an emit
//   step in ST_ROW, and dx climbs r and falls r in total; output stalls
//   lengthen the walk. A span is offered once the next visible row is
//   reached, the final one once the walk ends.
// Stalls and reset:
//   One span waits in a pending register until the next visible row or the
//   end of the disc decides its last flag; a stalled receiver holds the walk
//   at that point. Reset empties the output, returns to idle and sets
//   line_stride to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_disc_span_generator_top #(
	parameter int SCREEN_WIDTH  = fdsg_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fdsg_pkg::DEF_SCREEN_HEIGHT,
	parameter int MAX_RADIUS    = fdsg_pkg::DEF_MAX_RADIUS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command: centre_x[9:0], centre_y[19:10], radius[24:20],
	//          fill_colour[32:25], zero pad [39:33]
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fdsg_pkg::S_TDATA_W-1:0]      s_tdata,
	// span: row[7:0], span_start[15:8], span_length[24:16],
	//       start_address[42:25], span_colour[50:43], zero pad [55:51]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fdsg_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tlast,      // last_span
	// line_stride write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fdsg_pkg::STRIDE_W-1:0]       cfg_data
);

	fdsg_pkg::state_t                    state_q;
	logic [fdsg_pkg::STRIDE_W-1:0]       stride_q;

	// command registers
	logic signed [fdsg_pkg::CX_W-1:0]    cx_q;
	logic signed [fdsg_pkg::CY_W-1:0]    cy_q;
	logic        [fdsg_pkg::RAD_W-1:0]   r_q;
	logic        [fdsg_pkg::COL_W-1:0]   colour_q;

	// walk state
	logic signed [fdsg_pkg::DY_W-1:0]    dy_q;
	logic        [fdsg_pkg::REM_W-1:0]   rem_q;
	logic        [fdsg_pkg::RAD_W-1:0]   dx_q;
	logic        [fdsg_pkg::SQ_W-1:0]    sq_q;

	// one span held back until its last flag is known
	logic                                pend_valid_q;
	fdsg_pkg::span_t                     pend_q;

	// output register
	logic                                out_valid_q;
	logic                                out_last_q;
	fdsg_pkg::span_t                     out_q;
	logic        [fdsg_pkg::COL_W-1:0]   out_colour_q;

	fdsg_pkg::hw_step_t                  step;
	fdsg_pkg::span_t                     span;

	logic                                in_fire;
	logic                                out_free;
	logic                                row_last;
	logic                                push;
	logic                                push_last;
	logic        [fdsg_pkg::RAD_W-1:0]   r_in;
	logic signed [11:0]                  rem_wide;

	fdsg_hw_unit u_hw (
		.dx     (dx_q),
		.sq     (sq_q),
		.rem    (rem_q),
		.radius (r_q),
		.step   (step)
	);

	fdsg_span_unit #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_span (
		.cx     (cx_q),
		.cy     (cy_q),
		.dy     (dy_q),
		.dx     (dx_q),
		.stride (stride_q),
		.span   (span)
	);

	assign s_tready  = (state_q == fdsg_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign row_last  = (dy_q == $signed({1'b0, r_q}));

	// saturate the requested radius
	assign r_in = (s_tdata[24:20] > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : s_tdata[24:20];

	// r^2 - (dy+1)^2 = rem - (2*dy + 1)
	assign rem_wide = $signed({2'b0, rem_q}) - $signed({{5{dy_q[5]}}, dy_q, 1'b1});

	// move the pending span to the output register
	assign push = out_free && pend_valid_q &&
		(((state_q == fdsg_pkg::ST_ROW) && span.visible) ||
		 (state_q == fdsg_pkg::ST_FLUSH));
	assign push_last = (state_q == fdsg_pkg::ST_FLUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= fdsg_pkg::STRIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			stride_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fdsg_pkg::ST_IDLE;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				fdsg_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q      <= fdsg_pkg::ST_ADJ;
						pend_valid_q <= 1'b0;
					end
				end
				fdsg_pkg::ST_ADJ: begin
					if (step.settled) begin
						state_q <= fdsg_pkg::ST_ROW;
					end
				end
				fdsg_pkg::ST_ROW: begin
					// hold a visible row while the pending span cannot leave
					if (!span.visible || !pend_valid_q || out_free) begin
						if (span.visible) begin
							pend_valid_q <= 1'b1;
						end
						state_q <= row_last ? fdsg_pkg::ST_FLUSH : fdsg_pkg::ST_ADJ;
					end
				end
				fdsg_pkg::ST_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= fdsg_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fdsg_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// command and walk datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cx_q     <= s_tdata[9:0];
			cy_q     <= s_tdata[19:10];
			r_q      <= r_in;
			colour_q <= s_tdata[32:25];
			dy_q     <= 6'sd0 - $signed({1'b0, r_in});
			rem_q    <= '0;
			dx_q     <= '0;
			sq_q     <= 11'd1;
		end else if (state_q == fdsg_pkg::ST_ADJ) begin
			dx_q <= step.dx_next;
			sq_q <= step.sq_next;
		end else if ((state_q == fdsg_pkg::ST_ROW) &&
		             (!span.visible || !pend_valid_q || out_free)) begin
			if (span.visible) begin
				pend_q <= span;
			end
			if (!row_last) begin
				dy_q  <= dy_q + 6'sd1;
				rem_q <= rem_wide[9:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q        <= pend_q;
			out_last_q   <= push_last;
			out_colour_q <= colour_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'b0, out_colour_q, out_q.address, out_q.length,
	                   out_q.start, out_q.row};

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdsg_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("span left pending after the disc finished");

	a_dx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdsg_pkg::ST_ROW) |-> (dx_q <= r_q))
		else $error("half width exceeds radius");

	a_flush_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == fdsg_pkg::ST_FLUSH) && push) |=>
		(m_tvalid && m_tlast && (state_q == fdsg_pkg::ST_IDLE)))
		else $error("final span not flagged last");

endmodule

`default_nettype wire

>>> tb/filled_disc_span_generator_top_tb.sv
// ----------------------------------------------------------------------------
// Filled disc span generator testbench
// Sends disc commands with random gaps and receives spans under random stalls.
// Each span is checked against spans predicted from the command and stride.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_disc_span_generator_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// Before a stride write, also wait out more than the longest walk, because
	// off-screen discs can still be walking with nothing left in the queue.
	localparam int DISC_WALK_CYCLES = 256;
	// Allow the settle pause, the longest walk, a long stall and the hold-off.
	localparam int QUIET_LIMIT      = 2000;
	localparam int HOLD_OFF_CYCLES  = 400;
	localparam int PRINT_LIMIT      = 100;

	typedef struct packed {
		logic [fdsg_pkg::ROW_W-1:0]   row;
		logic [fdsg_pkg::START_W-1:0] start;
		logic [fdsg_pkg::LEN_W-1:0]   length;
		logic [fdsg_pkg::ADDR_W-1:0]  address;
		logic [fdsg_pkg::COL_W-1:0]   color;
		logic                         is_last;
	} span_rec_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	// centre_x, centre_y, radius, fill_colour, pad
	logic [fdsg_pkg::S_TDATA_W-1:0]   s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	// row, span_start, span_length, start_address, span_colour, pad
	logic [fdsg_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                             m_tlast;    // last_span
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [fdsg_pkg::STRIDE_W-1:0]    cfg_data;

	span_rec_t                        pending_spans[$];
	logic [fdsg_pkg::STRIDE_W-1:0]    line_stride;
	int                               mismatch_count = 0;
	bit                               idle_en = 1'b1;
	int                               hold_off_cycles = 0;

	filled_disc_span_generator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Queue the spans of one disc, top row first, and flag the final one.
	task automatic add_disc_spans(input logic signed [fdsg_pkg::CX_W-1:0] cx_in,
		input logic signed [fdsg_pkg::CY_W-1:0] cy_in,
		input logic [fdsg_pkg::RAD_W-1:0] rad_in,
		input logic [fdsg_pkg::COL_W-1:0] color_in);
		int        cx;
		int        cy;
		int        r;
		int        y;
		int        dx;
		int        x0;
		int        x1;
		int        spans;
		span_rec_t s;
		cx = int'(cx_in);
		cy = int'(cy_in);
		r = int'(rad_in);
		spans = 0;
		if (r > fdsg_pkg::DEF_MAX_RADIUS)
			r = fdsg_pkg::DEF_MAX_RADIUS;
		for (int dy = -r; dy <= r; dy++) begin
			y = cy + dy;
			if (y < 0 || y >= fdsg_pkg::DEF_SCREEN_HEIGHT)
				continue;
			// Grow dx while the next pixel still fits inside the circle.
			dx = 0;
			while (dx < r && (dx + 1) * (dx + 1) <= r * r - dy * dy)
				dx++;
			x0 = cx - dx;
			x1 = cx + dx + 1;
			if (x0 < 0)
				x0 = 0;
			if (x1 > fdsg_pkg::DEF_SCREEN_WIDTH)
				x1 = fdsg_pkg::DEF_SCREEN_WIDTH;
			if (x0 >= x1)
				continue;
			s.row     = fdsg_pkg::ROW_W'(y);
			s.start   = fdsg_pkg::START_W'(x0);
			s.length  = fdsg_pkg::LEN_W'(x1 - x0);
			s.address = fdsg_pkg::ADDR_W'(y * int'(line_stride) + x0);
			s.color   = color_in;
			s.is_last = 1'b0;
			pending_spans.push_back(s);
			spans++;
		end
		if (spans > 0)
			pending_spans[pending_spans.size() - 1].is_last = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want,
		input int row);
		if (got != want)
			report_mismatch($sformatf("row %0d %s: got %0d, expected %0d",
				row, name, got, want));
	endtask

	// Compare each delivered span with the oldest prediction.
	always @(posedge clk) begin : span_check
		span_rec_t got;
		span_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.row     = m_tdata[7:0];
			got.start   = m_tdata[15:8];
			got.length  = m_tdata[24:16];
			got.address = m_tdata[42:25];
			got.color   = m_tdata[50:43];
			got.is_last = m_tlast;
			if (pending_spans.size() == 0) begin
				report_mismatch($sformatf("unexpected span at row %0d", got.row));
			end else begin
				want = pending_spans.pop_front();
				check_field("row", got.row, want.row, want.row);
				check_field("span_start", got.start, want.start, want.row);
				check_field("span_length", got.length, want.length, want.row);
				check_field("start_address", got.address, want.address, want.row);
				check_field("span_colour", got.color, want.color, want.row);
				check_field("last_span", got.is_last, want.is_last, want.row);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		if (!idle_en)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one disc command, hold it until taken, then predict its spans.
	// Valid stays high on return; the next negedge either lowers it or
	// replaces the data.
	task automatic send_disc(input int cx, input int cy, input int rad,
		input int color);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {7'b0, fdsg_pkg::COL_W'(color), fdsg_pkg::RAD_W'(rad),
		            fdsg_pkg::CY_W'(cy), fdsg_pkg::CX_W'(cx)};
		do
			@(posedge clk);
		while (!s_tready);
		add_disc_spans(fdsg_pkg::CX_W'(cx), fdsg_pkg::CY_W'(cy),
			fdsg_pkg::RAD_W'(rad), fdsg_pkg::COL_W'(color));
	endtask

	// Wait out all spans and any silent walk, then write line_stride.
	task automatic write_line_stride(input int value);
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_spans.size() == 0);
		repeat (DISC_WALK_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = fdsg_pkg::STRIDE_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		line_stride = fdsg_pkg::STRIDE_W'(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Centre that mostly lands near the screen, sometimes anywhere.
	function automatic int pick_centre();
		if ($urandom_range(0, 99) < 85)
			return int'($urandom_range(0, 335)) - 40;
		return int'($urandom_range(0, 1023)) - 512;
	endfunction

	// Mostly small radii keep the walk short; a few reach the maximum.
	function automatic int pick_radius();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(0, 8);
		if (roll < 95)
			return $urandom_range(9, 20);
		return $urandom_range(21, 31);
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Field extremes and clipping on every screen edge, default stride.
	task automatic test_extremes();
		send_disc(100, 100, 0, 8'h00);      // single pixel
		send_disc(128, 128, 31, 8'hff);     // full disc, all rows
		send_disc(0, 0, 31, 8'h5a);         // clipped top and left
		send_disc(255, 255, 31, 8'ha5);     // clipped bottom and right
		send_disc(-31, 100, 31, 8'h01);     // touches column 0 only
		send_disc(286, 100, 31, 8'h80);     // touches column 255 only
		send_disc(100, -31, 31, 8'h7f);     // touches row 0 only
		send_disc(100, 286, 31, 8'hfe);     // touches row 255 only
		send_disc(511, 511, 1, 8'h33);
		send_disc(-512, 0, 2, 8'hcc);
		send_disc(341, -342, 31, 8'h55);    // alternating bit patterns
		send_disc(-342, 341, 21, 8'haa);
		send_disc(0, 255, 0, 8'h10);
		send_disc(255, 0, 1, 8'h20);
		send_disc(128, 64, 16, 8'h40);
	endtask

	// Discs that miss the screen give nothing; two visible ones are mixed in.
	task automatic test_off_screen();
		send_disc(-512, -512, 31, 8'h11);
		send_disc(511, 511, 31, 8'h22);
		send_disc(-32, 50, 31, 8'h33);      // right edge stops at column 0
		send_disc(287, 50, 31, 8'h44);      // left edge starts at column 256
		send_disc(50, -32, 31, 8'h55);
		send_disc(50, 287, 31, 8'h66);
		send_disc(10, 10, 3, 8'h77);
		send_disc(-1, -1, 0, 8'h88);
		send_disc(256, 20, 0, 8'h99);
		send_disc(200, 200, 4, 8'haa);
	endtask

	// Stride extremes, out-of-range values and wrap of the 18-bit address.
	task automatic test_stride_settings();
		int strides[6];
		strides = '{1, 1024, 0, 2047, int'($urandom_range(1, 1024)),
		            int'(fdsg_pkg::STRIDE_RESET)};
		foreach (strides[i]) begin
			write_line_stride(strides[i]);
			send_disc(128, 240, 20, $urandom_range(0, 255));
			send_disc(pick_centre(), pick_centre(), pick_radius(),
				$urandom_range(0, 255));
			send_disc(pick_centre(), pick_centre(), pick_radius(),
				$urandom_range(0, 255));
		end
	endtask

	// Hold the span output off long enough that the block stalls its input.
	task automatic test_output_backpressure();
		idle_en = 1'b0;
		hold_off_cycles = HOLD_OFF_CYCLES;
		for (int i = 0; i < 8; i++)
			send_disc(40 + 20 * i, 30 + 25 * i, 10, $urandom_range(0, 255));
		idle_en = 1'b1;
	endtask

	// Random discs, with a stretch of back-to-back traffic in the middle.
	task automatic test_random_discs(input int count);
		for (int i = 0; i < count; i++) begin
			idle_en = !(i >= count / 3 && i < count / 2);
			send_disc(pick_centre(), pick_centre(), pick_radius(),
				$urandom_range(0, 255));
			if (i == count / 2)
				write_line_stride($urandom_range(1, 1024));
		end
		idle_en = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Span receiver: random stalls, or a counted hold-off on request
	// ------------------------------------------------------------------------
	initial begin : span_receiver
		int stall_left;
		int roll;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				m_tready = 1'b0;
				hold_off_cycles--;
			end else if (!idle_en) begin
				m_tready = 1'b1;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					m_tready = 1'b1;
				end else if (roll < 95) begin
					m_tready = 1'b0;
					stall_left = $urandom_range(0, 2);
				end else begin
					m_tready = 1'b0;
					stall_left = $urandom_range(10, 40);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when nothing moves for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
		$display("** filled_disc_span_generator_top: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		line_stride = fdsg_pkg::STRIDE_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_off_screen();
		test_stride_settings();
		test_output_backpressure();
		test_random_discs(80);

		// Drop valid, drain the spans, then give any silent walk time to end.
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_spans.size() == 0);
		repeat (DISC_WALK_CYCLES) @(posedge clk);
		if (pending_spans.size() != 0)
			report_mismatch($sformatf("%0d spans never delivered",
				pending_spans.size()));
		if (mismatch_count == 0)
			$display("** filled_disc_span_generator_top: PASSED **");
		else
			$display("** filled_disc_span_generator_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
hdl/fdsg_pkg.sv
hdl/fdsg_hw_unit.sv
hdl/fdsg_span_unit.sv
hdl/filled_disc_span_generator_top.sv
tb/filled_disc_span_generator_top_tb.sv
